// ===== sv/lss_pkg.sv =====
`timescale 1ns / 1ps

package lss_pkg;

	// Default data format: signed Q16.16 in 32 bits.
	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	// Width of the singular threshold register.
	localparam int THR_WIDTH = 31;

	function automatic int max_int(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

endpackage

// ===== sv/lss_cofactor.sv =====
`timescale 1ns / 1ps

module lss_cofactor #(
	parameter int DW = lss_pkg::DATA_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 v_in,
	input  logic signed [DW-1:0] a_in  [9],
	input  logic signed [DW-1:0] b_in  [3],
	output logic                 v_out,
	output logic signed [DW-1:0] a_out [3],
	output logic signed [DW-1:0] b_out [3],
	output logic signed [2*DW:0] minor [9]
);

	// Minor k is a[PI]*a[QI] - a[RI]*a[SI], row-major minor index.
	localparam int PI [9] = '{4, 3, 3, 1, 0, 0, 1, 0, 0};
	localparam int QI [9] = '{8, 8, 7, 8, 8, 7, 5, 5, 4};
	localparam int RI [9] = '{5, 5, 4, 2, 2, 1, 2, 2, 1};
	localparam int SI [9] = '{7, 6, 6, 7, 6, 6, 4, 3, 3};

	logic                   v_s1, v_s2;
	logic signed [2*DW-1:0] pq_s1 [9];
	logic signed [2*DW-1:0] rs_s1 [9];
	logic signed [DW-1:0]   a_s1  [3];
	logic signed [DW-1:0]   b_s1  [3];
	logic signed [2*DW:0]   minor_s2 [9];
	logic signed [DW-1:0]   a_s2  [3];
	logic signed [DW-1:0]   b_s2  [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) begin
				pq_s1[k] <= a_in[PI[k]] * a_in[QI[k]];
				rs_s1[k] <= a_in[RI[k]] * a_in[SI[k]];
				minor_s2[k] <= $signed({pq_s1[k][2*DW-1], pq_s1[k]})
					- $signed({rs_s1[k][2*DW-1], rs_s1[k]});
			end
			for (int t = 0; t < 3; t++) begin
				a_s1[t] <= a_in[t];
				b_s1[t] <= b_in[t];
				a_s2[t] <= a_s1[t];
				b_s2[t] <= b_s1[t];
			end
		end
	end

	assign v_out = v_s2;
	assign a_out = a_s2;
	assign b_out = b_s2;
	assign minor = minor_s2;

endmodule

// ===== sv/lss_expand.sv =====
`timescale 1ns / 1ps

module lss_expand #(
	parameter int DW = lss_pkg::DATA_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   v_in,
	input  logic signed [DW-1:0]   a_in  [3],
	input  logic signed [DW-1:0]   b_in  [3],
	input  logic signed [2*DW:0]   minor [9],
	output logic                   v_out,
	output logic signed [3*DW+2:0] det,
	output logic signed [3*DW+2:0] num [3]
);

	localparam int TW = 3 * DW + 1;
	localparam int SW = 3 * DW + 3;
	localparam int LW = 2 * DW + 2;
	localparam int HW = 2 * DW;

	// Twelve products: group 0 forms the determinant, groups 1 to 3 the
	// adjugate rows times b. Each minor is split into a low unsigned part
	// of DW + 1 bits and a high signed part of DW bits, keeping multipliers narrow.
	logic signed [DW-1:0] fac [12];
	logic signed [2*DW:0] mnr [12];
	logic signed [TW-1:0] tsum [12];

	logic                 v_s3, v_s4, v_s5;
	logic signed [LW-1:0] lo_s3 [12];
	logic signed [HW-1:0] hi_s3 [12];
	logic signed [TW-1:0] term_s4 [12];
	logic signed [SW-1:0] sum_s5 [4];

	always_comb begin
		for (int o = 0; o < 4; o++) begin
			for (int t = 0; t < 3; t++) begin
				fac[3*o+t] = (o == 0) ? a_in[t] : b_in[t];
				mnr[3*o+t] = (o == 0) ? minor[t] : minor[3*t+o-1];
			end
		end
	end

	always_comb begin
		for (int j = 0; j < 12; j++) begin
			tsum[j] = {hi_s3[j], {(DW+1){1'b0}}}
				+ {{(TW-LW){lo_s3[j][LW-1]}}, lo_s3[j]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_in;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 12; j++) begin
				lo_s3[j] <= fac[j] * $signed({1'b0, mnr[j][DW:0]});
				hi_s3[j] <= fac[j] * $signed(mnr[j][2*DW:DW+1]);
				// The middle term is subtracted, and all three flip for x1.
				if (((j % 3) == 1) != ((j / 3) == 2)) begin
					term_s4[j] <= -tsum[j];
				end else begin
					term_s4[j] <= tsum[j];
				end
			end
			for (int o = 0; o < 4; o++) begin
				sum_s5[o] <= {{2{term_s4[3*o][TW-1]}}, term_s4[3*o]}
					+ {{2{term_s4[3*o+1][TW-1]}}, term_s4[3*o+1]}
					+ {{2{term_s4[3*o+2][TW-1]}}, term_s4[3*o+2]};
			end
		end
	end

	assign v_out  = v_s5;
	assign det    = sum_s5[0];
	assign num[0] = sum_s5[1];
	assign num[1] = sum_s5[2];
	assign num[2] = sum_s5[3];

endmodule

// ===== sv/lss_divider.sv =====
`timescale 1ns / 1ps

module lss_divider #(
	parameter int DW  = lss_pkg::DATA_WIDTH_DEF,
	parameter int NW  = 3 * lss_pkg::DATA_WIDTH_DEF + 3 + lss_pkg::FRAC_BITS_DEF,
	parameter int DDW = 3 * lss_pkg::DATA_WIDTH_DEF + 3,
	parameter int SBW = lss_pkg::DATA_WIDTH_DEF + 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           v_in,
	input  logic [NW-1:0]  num_in [3],
	input  logic [DDW-1:0] den_in,
	input  logic [SBW-1:0] sb_in,
	output logic           v_out,
	output logic [DW-1:0]  quo [3],
	output logic [SBW-1:0] sb_out
);

	import lss_pkg::*;

	localparam int RW = max_int(NW, DDW + DW);

	// Restoring division, one quotient bit per stage, most significant first.
	// The quotient is known to fit in DW bits whenever it is used.
	logic           v_s   [DW];
	logic [RW-1:0]  rem_s [DW-1][3];
	logic [DW-1:0]  quo_s [DW][3];
	logic [DDW-1:0] den_s [DW-1];
	logic [SBW-1:0] sb_s  [DW];

	for (genvar i = 0; i < DW; i++) begin : g_stage
		localparam int K = DW - 1 - i;

		logic           v_src;
		logic [RW-1:0]  rem_src [3];
		logic [DW-1:0]  quo_src [3];
		logic [DDW-1:0] den_src;
		logic [SBW-1:0] sb_src;
		logic [RW-1:0]  dsh;
		logic [RW-1:0]  rem_nxt [3];
		logic [DW-1:0]  quo_nxt [3];

		if (i == 0) begin : g_first
			assign v_src   = v_in;
			assign den_src = den_in;
			assign sb_src  = sb_in;
			for (genvar l = 0; l < 3; l++) begin : g_lane
				assign rem_src[l] = RW'(num_in[l]);
				assign quo_src[l] = '0;
			end
		end else begin : g_next
			assign v_src   = v_s[i-1];
			assign den_src = den_s[i-1];
			assign sb_src  = sb_s[i-1];
			for (genvar l = 0; l < 3; l++) begin : g_lane
				assign rem_src[l] = rem_s[i-1][l];
				assign quo_src[l] = quo_s[i-1][l];
			end
		end

		assign dsh = RW'(den_src) << K;

		always_comb begin
			for (int l = 0; l < 3; l++) begin
				if (rem_src[l] >= dsh) begin
					rem_nxt[l] = rem_src[l] - dsh;
					quo_nxt[l] = quo_src[l] | (DW'(1) << K);
				end else begin
					rem_nxt[l] = rem_src[l];
					quo_nxt[l] = quo_src[l];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_src;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sb_s[i] <= sb_src;
				for (int l = 0; l < 3; l++) begin
					quo_s[i][l] <= quo_nxt[l];
				end
			end
		end

		if (i < DW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					den_s[i] <= den_src;
					for (int l = 0; l < 3; l++) begin
						rem_s[i][l] <= rem_nxt[l];
					end
				end
			end
		end
	end

	assign v_out  = v_s[DW-1];
	assign sb_out = sb_s[DW-1];
	assign quo[0] = quo_s[DW-1][0];
	assign quo[1] = quo_s[DW-1][1];
	assign quo[2] = quo_s[DW-1][2];

endmodule

// ===== sv/linear_solve_3x3_cramer.sv =====
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// req       req_valid / req_ready   a00 .. a22, b0, b1, b2
// cfg       cfg_valid / cfg_ready   cfg_data (singular threshold)
// rsp       rsp_valid / rsp_ready   x0, x1, x2, determinant, singular, overflow
//
// One item enters per cycle while the stages are not held. The divider
// resolves one quotient bit per stage for the three solution lanes.
// Reset clears the valid bits of every stage and loads the threshold with 1.
// All stages advance together; they hold only when the output register is
// full and not taken while the last divider stage holds an item, so bubbles
// still close up behind a waiting result.
module linear_solve_3x3_cramer #(
	parameter int DATA_WIDTH = lss_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = lss_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  logic signed [DATA_WIDTH-1:0] a00,
	input  logic signed [DATA_WIDTH-1:0] a01,
	input  logic signed [DATA_WIDTH-1:0] a02,
	input  logic signed [DATA_WIDTH-1:0] a10,
	input  logic signed [DATA_WIDTH-1:0] a11,
	input  logic signed [DATA_WIDTH-1:0] a12,
	input  logic signed [DATA_WIDTH-1:0] a20,
	input  logic signed [DATA_WIDTH-1:0] a21,
	input  logic signed [DATA_WIDTH-1:0] a22,
	input  logic signed [DATA_WIDTH-1:0] b0,
	input  logic signed [DATA_WIDTH-1:0] b1,
	input  logic signed [DATA_WIDTH-1:0] b2,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [lss_pkg::THR_WIDTH-1:0] cfg_data,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output logic signed [DATA_WIDTH-1:0] x0,
	output logic signed [DATA_WIDTH-1:0] x1,
	output logic signed [DATA_WIDTH-1:0] x2,
	output logic signed [DATA_WIDTH-1:0] determinant,
	output logic                         singular,
	output logic                         overflow
);

	import lss_pkg::*;

	localparam int W    = DATA_WIDTH;
	localparam int F    = FRAC_BITS;
	localparam int DETW = 3 * W + 3;
	localparam int NW   = DETW + F;
	localparam int SCW  = max_int(DETW, THR_WIDTH + 2 * F);
	localparam int BCW  = DETW + max_int(F, W);
	localparam int SBW  = W + 8;

	localparam logic [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] NEG_MIN = {1'b1, {(W-1){1'b0}}};

	logic [THR_WIDTH-1:0] thr_q;

	logic                   en;
	logic                   rsp_load;
	logic signed [W-1:0]    a_vec [9];
	logic signed [W-1:0]    b_vec [3];

	logic                   cof_v;
	logic signed [W-1:0]    cof_a [3];
	logic signed [W-1:0]    cof_b [3];
	logic signed [2*W:0]    cof_minor [9];

	logic                   exp_v;
	logic signed [DETW-1:0] exp_det;
	logic signed [DETW-1:0] exp_num [3];

	logic                   v_s6;
	logic [DETW-1:0]        det_mag_s6;
	logic                   det_neg_s6;
	logic [DETW-1:0]        num_mag_s6 [3];
	logic [2:0]             num_neg_s6;

	logic [DETW-1:0]        dq;
	logic                   dq_sat;
	logic [W-1:0]           dout_c;
	logic                   sing_c;
	logic [2:0]             big_c;

	logic                   v_s7;
	logic [DETW-1:0]        det_mag_s7;
	logic [DETW-1:0]        num_mag_s7 [3];
	logic                   sing_s7;
	logic                   dovf_s7;
	logic [2:0]             big_s7;
	logic [2:0]             xneg_s7;
	logic [W-1:0]           dout_s7;

	logic [NW-1:0]          div_num [3];
	logic [SBW-1:0]         div_sb_in;
	logic                   div_v;
	logic [W-1:0]           div_quo [3];
	logic [SBW-1:0]         div_sb;

	logic                   f_sing;
	logic                   f_dovf;
	logic [2:0]             f_big;
	logic [2:0]             f_neg;
	logic [W-1:0]           f_dout;
	logic [W-1:0]           x_c [3];
	logic                   ovf_c;

	logic [W-1:0]           x_q [3];
	logic [W-1:0]           det_q;
	logic                   sing_q;
	logic                   ovf_q;

	// The output register takes a result when it is empty or being emptied.
	// The rest of the pipeline may also move when its last stage is a bubble.
	assign rsp_load  = !rsp_valid || rsp_ready;
	assign en        = rsp_load || !div_v;
	assign req_ready = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_WIDTH'(1);
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	assign a_vec[0] = a00;
	assign a_vec[1] = a01;
	assign a_vec[2] = a02;
	assign a_vec[3] = a10;
	assign a_vec[4] = a11;
	assign a_vec[5] = a12;
	assign a_vec[6] = a20;
	assign a_vec[7] = a21;
	assign a_vec[8] = a22;
	assign b_vec[0] = b0;
	assign b_vec[1] = b1;
	assign b_vec[2] = b2;

	// Stages 1 and 2: the nine 2x2 minors.
	lss_cofactor #(
		.DW(W)
	) u_cofactor (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (req_valid),
		.a_in   (a_vec),
		.b_in   (b_vec),
		.v_out  (cof_v),
		.a_out  (cof_a),
		.b_out  (cof_b),
		.minor  (cof_minor)
	);

	// Stages 3 to 5: exact determinant and the three Cramer numerators.
	lss_expand #(
		.DW(W)
	) u_expand (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (cof_v),
		.a_in   (cof_a),
		.b_in   (cof_b),
		.minor  (cof_minor),
		.v_out  (exp_v),
		.det    (exp_det),
		.num    (exp_num)
	);

	// Stage 6: split every wide value into sign and magnitude. The negation
	// of the most negative value is still correct read as unsigned.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s6 <= exp_v;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_neg_s6 <= exp_det[DETW-1];
			det_mag_s6 <= exp_det[DETW-1] ? DETW'(-exp_det) : DETW'(exp_det);
			for (int l = 0; l < 3; l++) begin
				num_neg_s6[l] <= exp_num[l][DETW-1];
				num_mag_s6[l] <= exp_num[l][DETW-1] ? DETW'(-exp_num[l])
					: DETW'(exp_num[l]);
			end
		end
	end

	// Stage 7: singular test against the threshold at product scale, the
	// reported determinant, and a check of which quotients need more than
	// the data width (numerator at least divisor shifted by the width).
	always_comb begin
		dq = det_mag_s6 >> (2 * F);
		if (det_neg_s6) begin
			dq_sat = dq > (DETW'(1) << (W - 1));
		end else begin
			dq_sat = dq > ((DETW'(1) << (W - 1)) - DETW'(1));
		end
		if (dq_sat) begin
			dout_c = det_neg_s6 ? NEG_MIN : POS_MAX;
		end else begin
			dout_c = det_neg_s6 ? -dq[W-1:0] : dq[W-1:0];
		end
		sing_c = (det_mag_s6 == '0)
			|| (SCW'(det_mag_s6) < (SCW'(thr_q) << (2 * F)));
		for (int l = 0; l < 3; l++) begin
			big_c[l] = (BCW'(num_mag_s6[l]) << F) >= (BCW'(det_mag_s6) << W);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_mag_s7 <= det_mag_s6;
			num_mag_s7 <= num_mag_s6;
			sing_s7    <= sing_c;
			dovf_s7    <= dq_sat;
			big_s7     <= big_c;
			xneg_s7    <= num_neg_s6 ^ {3{det_neg_s6}};
			dout_s7    <= dout_c;
		end
	end

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			div_num[l] = NW'(num_mag_s7[l]) << F;
		end
	end

	assign div_sb_in = {sing_s7, dovf_s7, big_s7, xneg_s7, dout_s7};

	// Stages 8 onward: one quotient bit per stage for each lane.
	lss_divider #(
		.DW  (W),
		.NW  (NW),
		.DDW (DETW),
		.SBW (SBW)
	) u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (v_s7),
		.num_in (div_num),
		.den_in (det_mag_s7),
		.sb_in  (div_sb_in),
		.v_out  (div_v),
		.quo    (div_quo),
		.sb_out (div_sb)
	);

	assign {f_sing, f_dovf, f_big, f_neg, f_dout} = div_sb;

	// Final step: zero on a singular system, otherwise saturate and sign.
	// A negative quotient may reach the most negative code exactly.
	always_comb begin
		logic sat;
		ovf_c = f_dovf;
		for (int l = 0; l < 3; l++) begin
			if (f_neg[l]) begin
				sat = f_big[l] || (div_quo[l][W-1] && (div_quo[l][W-2:0] != '0));
			end else begin
				sat = f_big[l] || div_quo[l][W-1];
			end
			if (f_sing) begin
				x_c[l] = '0;
			end else if (sat) begin
				x_c[l] = f_neg[l] ? NEG_MIN : POS_MAX;
				ovf_c  = 1'b1;
			end else begin
				x_c[l] = f_neg[l] ? -div_quo[l] : div_quo[l];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid <= div_v;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load && div_v) begin
			x_q    <= x_c;
			det_q  <= f_dout;
			sing_q <= f_sing;
			ovf_q  <= ovf_c;
		end
	end

	assign x0          = x_q[0];
	assign x1          = x_q[1];
	assign x2          = x_q[2];
	assign determinant = det_q;
	assign singular    = sing_q;
	assign overflow    = ovf_q;

endmodule
